FILE: rtl/ptq_pkg.sv
// Package for the periodic timer queue: widths, command and result codes,
// and the queue entry type shared by front end, queue and back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptq_pkg;
	localparam int Capacity   = 16;
	localparam int SlotBits   = $clog2(Capacity);
	localparam int PeriodBits = 16;
	localparam int TimeBits   = 48;
	localparam int IdBits     = 16;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ADDED     = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_CANCELLED = 3'd2,
		KIND_NOOP      = 3'd3,
		KIND_FIRED     = 3'd4,
		KIND_DONE      = 3'd5
	} kind_t;

	// request handed from the front end to the back end
	typedef struct packed {
		cmd_t                  cmd;
		logic [PeriodBits-1:0] period;
		logic                  rearm;
		logic [IdBits-1:0]     cancel_id;
	} req_t;
endpackage
`default_nettype wire

FILE: rtl/ptq_front.sv
// Front end of the periodic timer queue: accepts requests, drops unknown
// commands, saturates a zero period and pushes into a two-entry queue.
// Depends on ptq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptq_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     cmd,
	input  wire logic [ptq_pkg::PeriodBits-1:0] period,
	input  wire logic                           rearm,
	input  wire logic [ptq_pkg::IdBits-1:0]     cancel_id,
	output logic                                req_valid,
	output ptq_pkg::req_t                       req,
	input  wire logic                           req_pop
);
	ptq_pkg::req_t fifo_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	ptq_pkg::req_t in_req;
	logic          push;

	// classify the incoming request
	always_comb begin
		in_req.cmd       = ptq_pkg::cmd_t'(cmd);
		in_req.period    = (period == '0) ? ptq_pkg::PeriodBits'(1) : period;
		in_req.rearm     = rearm;
		in_req.cancel_id = cancel_id;
	end

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy && (cmd != ptq_pkg::CMD_NONE);
	assign req_valid = (cnt_q != 2'd0);
	assign req       = fifo_q[rd_q];

	// hold queued requests
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_req;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (req_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(req_pop);
		end
	end

	ast_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |-> req_valid) else $error("pop from empty queue");
	ast_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> cnt_q != 2'd0) else $error("full queue drained without pop");
	ast_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
endmodule
`default_nettype wire

FILE: rtl/ptq_back.sv
// Back end of the periodic timer queue: slot storage, time and id state,
// and a sequencer that scans slots one per cycle.
// Depends on ptq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptq_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	input  ptq_pkg::req_t                     req,
	output logic                              req_pop,
	output logic                              strobe,
	output logic [2:0]                        kind,
	output logic [ptq_pkg::IdBits-1:0]        timer_id,
	output logic [ptq_pkg::TimeBits-1:0]      deadline,
	output logic                              last
);
	localparam int SB = ptq_pkg::SlotBits;
	localparam int TB = ptq_pkg::TimeBits;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIRE} state_t;

	logic [ptq_pkg::Capacity-1:0] used_q, fired_q;
	logic [TB-1:0]                 dl_q  [ptq_pkg::Capacity];
	logic [ptq_pkg::PeriodBits-1:0] per_q [ptq_pkg::Capacity];
	logic [ptq_pkg::IdBits-1:0]    id_q  [ptq_pkg::Capacity];
	logic [ptq_pkg::Capacity-1:0]  rarm_q;

	state_t              state_q;
	logic [TB-1:0]       now_q;
	logic [ptq_pkg::IdBits-1:0] next_id_q;
	logic [SB:0]         idx_q;
	logic                best_ok_q;
	logic [SB-1:0]       best_q;
	logic [TB-1:0]       best_age_q;

	// free slot and cancel match, lowest index first
	logic          free_hit, can_hit;
	logic [SB-1:0] free_idx, can_idx;
	always_comb begin
		free_hit = 1'b0; free_idx = '0;
		can_hit  = 1'b0; can_idx  = '0;
		for (int i = ptq_pkg::Capacity - 1; i >= 0; i--) begin
			if (!used_q[i]) begin free_hit = 1'b1; free_idx = SB'(i); end
			if (used_q[i] && id_q[i] == req.cancel_id) begin
				can_hit = 1'b1; can_idx = SB'(i);
			end
		end
	end

	// compare scanned slot against the current best
	logic [SB-1:0] cur;
	logic [TB-1:0] cur_age;
	logic          cur_due, cur_better;
	assign cur     = idx_q[SB-1:0];
	assign cur_age = now_q - dl_q[cur];
	assign cur_due = used_q[cur] && !fired_q[cur] && !cur_age[TB-1];
	always_comb begin
		priority if (!best_ok_q)                 cur_better = 1'b1;
		else if (cur_age != best_age_q)          cur_better = cur_age > best_age_q;
		else if (per_q[cur] != per_q[best_q])    cur_better = per_q[cur] < per_q[best_q];
		else                                     cur_better = id_q[cur] < id_q[best_q];
	end

	assign req_pop = (state_q == ST_IDLE) && req_valid;

	// sequence commands, hold state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			fired_q   <= '0;
			now_q     <= '0;
			next_id_q <= '0;
			idx_q     <= '0;
			best_ok_q <= 1'b0;
			strobe    <= 1'b0;
			last      <= 1'b0;
			kind      <= ptq_pkg::KIND_DONE;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						strobe <= 1'b1;
						last   <= 1'b1;
						unique case (req.cmd)
							ptq_pkg::CMD_ADD: begin
								if (free_hit) begin
									used_q[free_idx] <= 1'b1;
									next_id_q <= next_id_q + ptq_pkg::IdBits'(1);
									kind <= ptq_pkg::KIND_ADDED;
								end else begin
									kind <= ptq_pkg::KIND_FULL;
								end
							end
							ptq_pkg::CMD_CANCEL: begin
								if (can_hit) begin
									used_q[can_idx] <= 1'b0;
									kind <= ptq_pkg::KIND_CANCELLED;
								end else begin
									kind <= ptq_pkg::KIND_NOOP;
								end
							end
							default: begin
								strobe    <= 1'b0;
								now_q     <= now_q + TB'(1);
								fired_q   <= '0;
								idx_q     <= '0;
								best_ok_q <= 1'b0;
								state_q   <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (cur_due && cur_better) begin
						best_ok_q  <= 1'b1;
						best_q     <= cur;
						best_age_q <= cur_age;
					end
					idx_q <= idx_q + (SB+1)'(1);
					if (idx_q == (SB+1)'(ptq_pkg::Capacity - 1)) state_q <= ST_FIRE;
				end
				default: begin
					strobe <= 1'b1;
					idx_q     <= '0;
					best_ok_q <= 1'b0;
					if (best_ok_q) begin
						kind <= ptq_pkg::KIND_FIRED;
						last <= 1'b0;
						fired_q[best_q] <= 1'b1;
						if (!rarm_q[best_q]) used_q[best_q] <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						kind <= ptq_pkg::KIND_DONE;
						last <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// slot payload and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				timer_id <= '0;
				deadline <= '0;
				if (req_valid && req.cmd == ptq_pkg::CMD_ADD && free_hit) begin
					dl_q[free_idx]   <= now_q + TB'(req.period);
					per_q[free_idx]  <= req.period;
					id_q[free_idx]   <= next_id_q;
					rarm_q[free_idx] <= req.rearm;
					timer_id <= next_id_q;
					deadline <= now_q + TB'(req.period);
				end
				if (req_valid && req.cmd == ptq_pkg::CMD_CANCEL) timer_id <= req.cancel_id;
			end
			ST_SCAN: ;
			default: begin
				if (best_ok_q) begin
					timer_id <= id_q[best_q];
					deadline <= dl_q[best_q];
					if (rarm_q[best_q])
						dl_q[best_q] <= dl_q[best_q] + TB'(per_q[best_q]);
				end else begin
					timer_id <= '0;
					deadline <= now_q;
				end
			end
		endcase
	end

	ast_fire_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRE && best_ok_q) |-> used_q[best_q])
		else $error("firing an unused slot");
	ast_fire_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRE && best_ok_q) |-> !fired_q[best_q])
		else $error("slot fired twice in one tick");
	ast_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == ptq_pkg::KIND_DONE) |-> last)
		else $error("tick done without last");
	ast_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |=> !strobe || last) else $error("result after pop not final");
endmodule
`default_nettype wire

FILE: rtl/periodic_timer_queue_unit.sv
// Top level of the periodic timer queue: front end with request queue and
// back end with slot storage. Depends on ptq_pkg, ptq_front, ptq_back.
//
// Usage: drive cmd, period, rearm, cancel_id with start high; the request is
// taken at an edge where busy is low. Up to two requests wait in a queue
// between front and back end. Results appear for one cycle with strobe
// high (kind, timer_id, deadline, last); the receiver cannot stall them.
// Timing: add and cancel answer in the cycle after the back end takes them,
// and the back end stays idle, ready for the next request. A tick first
// advances time, then scans all 16 slots, one per cycle, for each fired
// event plus once more for the done marker; it holds the back end until
// the done marker, while up to two requests wait. Command 3 is taken and
// dropped with no result.
// Reset clears time, the id counter, slot occupancy and the queue; slot
// contents are left as they are and are read only once written.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_queue_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     cmd,
	input  wire logic [ptq_pkg::PeriodBits-1:0] period,
	input  wire logic                           rearm,
	input  wire logic [ptq_pkg::IdBits-1:0]     cancel_id,
	output logic                                strobe,
	output logic [2:0]                          kind,
	output logic [ptq_pkg::IdBits-1:0]          timer_id,
	output logic [ptq_pkg::TimeBits-1:0]        deadline,
	output logic                                last
);
	logic          req_valid, req_pop;
	ptq_pkg::req_t req;

	ptq_front u_front (
		.clk, .arst_n, .start, .busy, .cmd, .period, .rearm, .cancel_id,
		.req_valid, .req, .req_pop
	);

	ptq_back u_back (
		.clk, .arst_n, .req_valid, .req, .req_pop,
		.strobe, .kind, .timer_id, .deadline, .last
	);
endmodule
`default_nettype wire

FILE: bench/tb_periodic_timer_queue_unit.sv
// Testbench for periodic_timer_queue_unit: directed table and random command mix,
// all checked against a local model of the timer queue.
// Depends on ptq_pkg and the periodic_timer_queue_unit RTL.
`timescale 1ns / 1ps
module tb_periodic_timer_queue_unit;
	import ptq_pkg::*;

	typedef struct {
		kind_t                 kind;
		logic [IdBits-1:0]     id;
		logic [TimeBits-1:0]   dl;
		logic                  lst;
	} result_t;

	// one row of the directed table; reps repeats the row
	typedef struct {
		cmd_t                  cmd;
		logic [PeriodBits-1:0] per;
		logic                  rep;
		logic [IdBits-1:0]     cid;
		int                    reps;
		bit                    chk;
		kind_t                 kind;
		logic [IdBits-1:0]     id;
		logic [TimeBits-1:0]   dl;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            cmd = CMD_NONE;
	logic [PeriodBits-1:0] period = '0;
	logic                  rearm = 1'b0;
	logic [IdBits-1:0]     cancel_id = '0;
	logic                  strobe;
	logic [2:0]            kind;
	logic [IdBits-1:0]     timer_id;
	logic [TimeBits-1:0]   deadline;
	logic                  last;

	// model state
	logic [TimeBits-1:0]   m_now;
	logic [IdBits-1:0]     m_next_id;
	bit                    m_used [Capacity];
	logic [TimeBits-1:0]   m_dl [Capacity];
	logic [PeriodBits-1:0] m_per [Capacity];
	logic [IdBits-1:0]     m_id [Capacity];
	bit                    m_rep [Capacity];

	result_t pending_results[$];
	int      mismatches = 0;
	int      n_fired = 0;
	int      n_full = 0;
	int      n_results = 0;
	int      n_items = 0;
	int      n_pushed = 0;

	periodic_timer_queue_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .period(period), .rearm(rearm), .cancel_id(cancel_id),
		.strobe(strobe), .kind(kind), .timer_id(timer_id), .deadline(deadline), .last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [TimeBits-1:0] age(int s);
		return m_now - m_dl[s];
	endfunction

	// true if slot a fires ahead of slot b
	function automatic bit fires_first(int a, int b);
		if (age(a) != age(b))
			return age(a) > age(b);
		if (m_per[a] != m_per[b])
			return m_per[a] < m_per[b];
		if (m_id[a] != m_id[b])
			return m_id[a] < m_id[b];
		return a < b;
	endfunction

	function automatic void push(kind_t k, logic [IdBits-1:0] id, logic [TimeBits-1:0] dl);
		result_t r;
		r.kind = k;
		r.id = id;
		r.dl = dl;
		r.lst = 1'b0;
		pending_results.push_back(r);
		n_pushed++;
	endfunction

	// compute the results of one accepted request and advance the model
	function automatic void predict_queue(logic [1:0] c, logic [PeriodBits-1:0] p, logic rp,
			logic [IdBits-1:0] cid);
		int s;
		int best;
		bit fired [Capacity];
		logic [PeriodBits-1:0] per;
		logic [TimeBits-1:0] a;
		if (c == CMD_NONE)
			return;
		if (c == CMD_ADD) begin
			per = (p == 0) ? 1 : p;
			for (s = 0; s < Capacity; s++)
				if (!m_used[s])
					break;
			if (s == Capacity) begin
				push(KIND_FULL, '0, '0);
			end else begin
				m_used[s] = 1;
				m_per[s] = per;
				m_dl[s] = m_now + per;
				m_id[s] = m_next_id;
				m_rep[s] = rp;
				m_next_id = m_next_id + 1;
				push(KIND_ADDED, m_id[s], m_dl[s]);
			end
		end else if (c == CMD_CANCEL) begin
			for (s = 0; s < Capacity; s++)
				if (m_used[s] && m_id[s] == cid)
					break;
			if (s == Capacity) begin
				push(KIND_NOOP, cid, '0);
			end else begin
				m_used[s] = 0;
				push(KIND_CANCELLED, cid, '0);
			end
		end else begin
			foreach (fired[i])
				fired[i] = 0;
			m_now = m_now + 1;
			forever begin
				best = -1;
				for (s = 0; s < Capacity; s++) begin
					if (!m_used[s] || fired[s])
						continue;
					a = age(s);
					if (a[TimeBits-1])
						continue;
					if (best < 0 || fires_first(s, best))
						best = s;
				end
				if (best < 0)
					break;
				fired[best] = 1;
				push(KIND_FIRED, m_id[best], m_dl[best]);
				if (m_rep[best])
					m_dl[best] = m_dl[best] + m_per[best];
				else
					m_used[best] = 0;
			end
			push(KIND_DONE, '0, m_now);
		end
		pending_results[$].lst = 1'b1;
	endfunction

	function automatic void report(string what, result_t e, result_t a);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): expected kind %0d id %0d dl %0d last %0d, got kind %0d id %0d dl %0d last %0d",
				what, e.kind, e.id, e.dl, e.lst, a.kind, a.id, a.dl, a.lst);
	endfunction

	// check each strobed result against the oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && strobe) begin
			got.kind = kind_t'(kind);
			got.id = timer_id;
			got.dl = deadline;
			got.lst = last;
			n_results++;
			if (got.kind == KIND_FIRED)
				n_fired++;
			if (got.kind == KIND_FULL)
				n_full++;
			if (pending_results.size() == 0) begin
				want.kind = KIND_DONE;
				want.id = '0;
				want.dl = '0;
				want.lst = 1'b0;
				report("unexpected result", want, got);
			end else begin
				want = pending_results.pop_front();
				if (got.kind != want.kind || got.id != want.id || got.dl != want.dl
						|| got.lst != want.lst)
					report("field", want, got);
			end
		end
	end

	// hold the request on the ports until an edge with busy low takes it
	task automatic send_request(logic [1:0] c, logic [PeriodBits-1:0] p, logic rp,
			logic [IdBits-1:0] cid);
		start <= 1'b1;
		cmd <= c;
		period <= p;
		rearm <= rp;
		cancel_id <= cid;
		do
			@(posedge clk);
		while (busy);
		predict_queue(c, p, rp, cid);
		n_items++;
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [IdBits-1:0] pick_live_id();
		int s;
		s = $urandom_range(Capacity - 1);
		for (int k = 0; k < Capacity; k++)
			if (m_used[(s + k) % Capacity])
				return m_id[(s + k) % Capacity];
		return IdBits'($urandom);
	endfunction

	row_t table_rows[$];

	initial begin
		row_t r;
		int idx;
		int first;
		int x;
		logic [1:0] c;
		logic [PeriodBits-1:0] p;

		// reset model
		m_now = '0;
		m_next_id = '0;
		foreach (m_used[i])
			m_used[i] = 0;

		// directed rows: zero period, extremes, cancel hit and miss, due order, full queue
		table_rows = '{
			'{CMD_ADD, 16'd0, 1'b0, 16'd0, 1, 1, KIND_ADDED, 16'd0, 48'd1},
			'{CMD_ADD, 16'hFFFF, 1'b1, 16'hFFFF, 1, 1, KIND_ADDED, 16'd1, 48'd65535},
			'{CMD_CANCEL, 16'd0, 1'b0, 16'd1, 1, 1, KIND_CANCELLED, 16'd1, 48'd0},
			'{CMD_CANCEL, 16'hFFFF, 1'b1, 16'hFFFF, 1, 1, KIND_NOOP, 16'hFFFF, 48'd0},
			'{CMD_TICK, 16'd0, 1'b0, 16'd0, 1, 1, KIND_FIRED, 16'd0, 48'd1},
			'{CMD_NONE, 16'hFFFF, 1'b1, 16'hFFFF, 1, 0, KIND_DONE, 16'd0, 48'd0},
			'{CMD_ADD, 16'd2, 1'b1, 16'd0, 3, 0, KIND_DONE, 16'd0, 48'd0},
			'{CMD_ADD, 16'd1, 1'b1, 16'd0, 2, 0, KIND_DONE, 16'd0, 48'd0},
			'{CMD_ADD, 16'd3, 1'b0, 16'd0, 11, 0, KIND_DONE, 16'd0, 48'd0},
			'{CMD_ADD, 16'd5, 1'b0, 16'd0, 1, 1, KIND_FULL, 16'd0, 48'd0},
			'{CMD_TICK, 16'd0, 1'b0, 16'd0, 5, 0, KIND_DONE, 16'd0, 48'd0},
			'{CMD_CANCEL, 16'd0, 1'b0, 16'd2, 1, 0, KIND_DONE, 16'd0, 48'd0},
			'{CMD_CANCEL, 16'd0, 1'b0, 16'd5, 1, 0, KIND_DONE, 16'd0, 48'd0},
			'{CMD_TICK, 16'd0, 1'b0, 16'd0, 2, 0, KIND_DONE, 16'd0, 48'd0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (table_rows[i]) begin
			r = table_rows[i];
			repeat (r.reps) begin
				first = n_pushed;
				send_request(r.cmd, r.per, r.rep, r.cid);
				idx = pending_results.size() - (n_pushed - first);
				if (r.chk && (pending_results[idx].kind != r.kind
						|| pending_results[idx].id != r.id || pending_results[idx].dl != r.dl))
					report("table", '{r.kind, r.id, r.dl, pending_results[idx].lst},
						pending_results[idx]);
				idle_gap(random_gap());
			end
		end
		drain_results();

		// random mix of adds, cancels, ticks and unknown commands
		for (int n = 0; n < 400; n++) begin
			x = $urandom_range(99);
			p = ($urandom_range(9) == 0) ? PeriodBits'($urandom) : PeriodBits'($urandom_range(0, 9));
			if (x < 38)
				c = CMD_ADD;
			else if (x < 56)
				c = CMD_CANCEL;
			else if (x < 95)
				c = CMD_TICK;
			else
				c = CMD_NONE;
			send_request(c, p, $urandom_range(1),
				($urandom_range(1) != 0) ? pick_live_id() : IdBits'($urandom));
			if (n == 200)
				drain_results();
			else
				idle_gap(random_gap());
		end

		drain_results();
		repeat (60) @(posedge clk);
		$display("Ran %0d requests, %0d results checked, %0d firings, %0d queue-full answers.",
			n_items, n_results, n_fired, n_full);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end
endmodule
